### rtl/integer_to_text_formatter_defines.svh
// assertion macros used by the checker file
`ifndef INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_DEFINES_SVH

// same-cycle implication
`define ITF_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ITF_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/itf_pkg.sv
// shared constants, types and the digit character function of the formatter
`timescale 1ns / 1ps

package itf_pkg;

   localparam int VALUE_BITS_DEF = 32;
   localparam int MAX_DIGITS_DEF = 32;
   localparam int MAX_WIDTH_DEF  = 64;

   localparam int BASE_W   = 6;
   localparam int WIDTH_W  = 8;
   localparam int PREC_W   = 6;
   localparam int FLAG_W   = 7;
   localparam int CHAR_W   = 8;
   localparam int CNT_W    = 9;
   localparam int DIV_BITS = 8;

   localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0] BASE_MAX   = 6'd36;
   localparam logic [BASE_W-1:0] BASE_OCT   = 6'd8;
   localparam logic [BASE_W-1:0] BASE_HEX   = 6'd16;
   localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

   localparam int FLAG_LEFT    = 0;
   localparam int FLAG_ZEROPAD = 1;
   localparam int FLAG_PLUS    = 2;
   localparam int FLAG_SPACE   = 3;
   localparam int FLAG_PREFIX  = 4;
   localparam int FLAG_LOWER   = 5;
   localparam int FLAG_SIGNED  = 6;

   localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_A_UP  = 8'h41;
   localparam logic [CHAR_W-1:0] CHAR_X_UP  = 8'h58;
   localparam logic [CHAR_W-1:0] CHAR_A_LO  = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_X_LO  = 8'h78;

   typedef struct packed {
      logic load;
      logic err;
      logic div_step;
      logic calc_len;
      logic calc_pos;
      logic emit_step;
   } ctrl_cmd_type;

   typedef struct packed {
      logic bad_base;
      logic digit_end;
      logic quot_zero;
      logic digits_full;
      logic emit_none;
      logic emit_last;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d,
                                                    input logic lower);
      logic [CHAR_W-1:0] d8;
      d8 = CHAR_W'(d);
      if (d < DEC_DIGITS) begin
         return CHAR_ZERO + d8;
      end else if (lower) begin
         return CHAR_A_LO + d8 - CHAR_W'(DEC_DIGITS);
      end else begin
         return CHAR_A_UP + d8 - CHAR_W'(DEC_DIGITS);
      end
   endfunction

endpackage

### rtl/itf_ram.sv
// generic single-port-write ram with registered read
`timescale 1ns / 1ps

module itf_ram #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/itf_ctrl.sv
// sequencing state machine of the formatter
`timescale 1ns / 1ps

module itf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  itf_pkg::dp_status_type status,
   output itf_pkg::ctrl_cmd_type  cmd
);

   typedef enum logic [2:0] {S_IDLE, S_DIV, S_LEN, S_POS, S_EMIT} state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (status.bad_base) begin
                  cmd.err = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (status.digit_end && (status.quot_zero || status.digits_full)) begin
               state_in = S_LEN;
            end
         end
         S_LEN: begin
            cmd.calc_len = 1'b1;
            state_in     = S_POS;
         end
         S_POS: begin
            cmd.calc_pos = 1'b1;
            state_in     = S_EMIT;
         end
         S_EMIT: begin
            if (status.emit_none) begin
               state_in = S_IDLE;
            end else begin
               cmd.emit_step = 1'b1;
               if (status.emit_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         busy_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign busy = busy_ff;

endmodule

### rtl/itf_datapath.sv
// digit extraction, field layout and character generation of the formatter
`timescale 1ns / 1ps

module itf_datapath #(
   parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = itf_pkg::MAX_DIGITS_DEF,
   parameter int MAX_WIDTH  = itf_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [VALUE_BITS-1:0]               req_value,
   input  logic [itf_pkg::BASE_W-1:0]          req_base,
   input  logic signed [itf_pkg::WIDTH_W-1:0]  req_width,
   input  logic [itf_pkg::PREC_W-1:0]          req_precision,
   input  logic [itf_pkg::FLAG_W-1:0]          req_format_flags,
   input  itf_pkg::ctrl_cmd_type               cmd,
   output itf_pkg::dp_status_type              status,
   output logic                                rsp_strobe,
   output logic [itf_pkg::CHAR_W-1:0]          rsp_out_char,
   output logic                                rsp_last_char,
   output logic                                rsp_bad_base
);

   localparam int DB         = itf_pkg::DIV_BITS;
   localparam int DIV_CYCLES = (VALUE_BITS + DB - 1) / DB;
   localparam int PAD_BITS   = DIV_CYCLES * DB;
   localparam int DC_W       = $clog2(DIV_CYCLES + 1);
   localparam int ND_W       = $clog2(MAX_DIGITS + 1);
   localparam int AW         = $clog2(MAX_DIGITS);
   localparam int CW         = itf_pkg::CNT_W;
   localparam int SW         = itf_pkg::CNT_W + 1;
   localparam int BW         = itf_pkg::BASE_W;
   localparam int WW         = itf_pkg::WIDTH_W;
   localparam int PW         = itf_pkg::PREC_W;
   localparam logic signed [WW-1:0] WIDTH_CAP = WW'(MAX_WIDTH);
   localparam logic [PW-1:0]        PREC_CAP  = PW'(MAX_WIDTH - 3);

   typedef enum logic [2:0] {K_SPACE, K_SIGN, K_ZERO, K_X, K_DIGIT, K_ERR} kind_type;

   // division state
   logic [PAD_BITS-1:0] work_ff, work_in;
   logic [BW-1:0]       rem_ff, rem_in;
   logic [DC_W-1:0]     divc_ff, divc_in;
   logic [ND_W-1:0]     nd_ff, nd_in;

   // captured item
   logic [BW-1:0]                  base_ff, base_in;
   logic signed [WW-1:0]           width_ff, width_in;
   logic [PW-1:0]                  prec_ff, prec_in;
   logic                           has_sign_ff, has_sign_in;
   logic [itf_pkg::CHAR_W-1:0]     sign_char_ff, sign_char_in;
   logic [1:0]                     pc_ff, pc_in;
   logic                           lower_ff, lower_in;
   logic                           left_ff, left_in;
   logic                           zp_ff, zp_in;

   // field layout
   logic [CW-1:0] lead_ff, lead_in, zc_ff, zc_in, dig_ff, dig_in, trail_ff, trail_in;
   logic [CW-1:0] b1_ff, b1_in, b2_ff, b2_in, b3_ff, b3_in, b4_ff, b4_in, b5_ff, b5_in;
   logic [CW-1:0] n_ff, n_in, idx_ff, idx_in;

   // output beat
   logic     strobe_ff, strobe_in;
   logic     last_ff, last_in;
   kind_type kind_ff, kind_in;

   // combinational helpers
   logic                     neg;
   logic [VALUE_BITS-1:0]    mag;
   logic [BW-1:0]            r;
   logic [BW:0]              t;
   logic [DB-1:0]            q;
   logic [PAD_BITS-1:0]      work_next;
   logic signed [SW-1:0]     off0, nd_s, prec_s, tl, show, spare, r_pad;
   logic                     short_w;
   logic [CW-1:0]            tot, dig_addr;
   logic [BW-1:0]            rd_data;
   logic                     wr_en;
   logic [itf_pkg::FLAG_W-1:0] fl;
   int                       j;

   // one radix digit: DB restoring steps per cycle on a narrow remainder
   always_comb begin
      r = rem_ff;
      q = '0;
      t = '0;
      for (j = 0; j < DB; j++) begin
         t = {r, work_ff[PAD_BITS-1-j]};
         if (t >= {1'b0, base_ff}) begin
            t            = t - {1'b0, base_ff};
            q[DB-1-j]    = 1'b1;
         end
         r = t[BW-1:0];
      end
      work_next = (work_ff << DB) | PAD_BITS'(q);
   end

   always_comb begin
      fl  = req_format_flags;
      neg = fl[itf_pkg::FLAG_SIGNED] && req_value[VALUE_BITS-1];
      mag = neg ? (~req_value + VALUE_BITS'(1)) : req_value;

      off0    = $signed({{(SW-WW){width_ff[WW-1]}}, width_ff})
                - $signed(SW'(has_sign_ff)) - $signed(SW'(pc_ff));
      nd_s    = $signed(SW'(nd_ff));
      prec_s  = $signed(SW'(prec_ff));
      tl      = (nd_s > prec_s) ? nd_s : prec_s;
      short_w = (off0 >= 0) && (off0 < tl);
      show    = nd_s + off0 - tl;
      spare   = off0 - tl;
      r_pad   = (spare > 0) ? spare : '0;
      tot     = '0;

      work_in      = work_ff;
      rem_in       = rem_ff;
      divc_in      = divc_ff;
      nd_in        = nd_ff;
      base_in      = base_ff;
      width_in     = width_ff;
      prec_in      = prec_ff;
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      pc_in        = pc_ff;
      lower_in     = lower_ff;
      left_in      = left_ff;
      zp_in        = zp_ff;
      lead_in      = lead_ff;
      zc_in        = zc_ff;
      dig_in       = dig_ff;
      trail_in     = trail_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      b3_in        = b3_ff;
      b4_in        = b4_ff;
      b5_in        = b5_ff;
      n_in         = n_ff;
      idx_in       = idx_ff;
      strobe_in    = 1'b0;
      last_in      = last_ff;
      kind_in      = kind_ff;
      wr_en        = 1'b0;
      dig_addr     = b5_ff - idx_ff - CW'(1);

      if (cmd.load) begin
         work_in  = PAD_BITS'(mag);
         rem_in   = '0;
         divc_in  = '0;
         nd_in    = '0;
         base_in  = req_base;
         width_in = (req_width > WIDTH_CAP) ? WIDTH_CAP : req_width;
         prec_in  = (req_precision > PREC_CAP) ? PREC_CAP : req_precision;
         lower_in = fl[itf_pkg::FLAG_LOWER];
         left_in  = fl[itf_pkg::FLAG_LEFT];
         // left justification cancels zero padding
         zp_in    = fl[itf_pkg::FLAG_ZEROPAD] && !fl[itf_pkg::FLAG_LEFT];
         has_sign_in  = neg || fl[itf_pkg::FLAG_PLUS] || fl[itf_pkg::FLAG_SPACE];
         sign_char_in = neg ? itf_pkg::CHAR_MINUS :
                        fl[itf_pkg::FLAG_PLUS] ? itf_pkg::CHAR_PLUS : itf_pkg::CHAR_SPACE;
         pc_in = '0;
         if (fl[itf_pkg::FLAG_PREFIX]) begin
            if (req_base == itf_pkg::BASE_HEX) begin
               pc_in = 2'd2;
            end else if (req_base == itf_pkg::BASE_OCT) begin
               pc_in = 2'd1;
            end
         end
      end

      if (cmd.div_step) begin
         if (divc_ff == DC_W'(DIV_CYCLES - 1)) begin
            wr_en   = 1'b1;
            nd_in   = nd_ff + ND_W'(1);
            rem_in  = '0;
            divc_in = '0;
         end else begin
            rem_in  = r;
            divc_in = divc_ff + DC_W'(1);
         end
         work_in = work_next;
      end

      if (cmd.calc_len) begin
         if (short_w) begin
            // only the low-order digits survive, no padding
            lead_in  = '0;
            zc_in    = '0;
            dig_in   = (show > 0) ? CW'(show) : '0;
            trail_in = '0;
         end else begin
            lead_in  = (!zp_ff && !left_ff) ? CW'(r_pad) : '0;
            zc_in    = (zp_ff ? CW'(r_pad) : '0) + CW'(tl - nd_s);
            dig_in   = CW'(nd_ff);
            trail_in = left_ff ? CW'(r_pad) : '0;
         end
      end

      if (cmd.calc_pos) begin
         b1_in  = lead_ff;
         b2_in  = lead_ff + CW'(has_sign_ff);
         b3_in  = b2_in + CW'(pc_ff);
         b4_in  = b3_in + zc_ff;
         b5_in  = b4_in + dig_ff;
         idx_in = '0;
         // total length, capped at the field maximum
         tot    = b5_in + trail_ff;
         n_in   = (tot > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : tot;
      end

      if (cmd.emit_step) begin
         strobe_in = 1'b1;
         last_in   = (idx_ff == n_ff - CW'(1));
         idx_in    = idx_ff + CW'(1);
         if (idx_ff < b1_ff) begin
            kind_in = K_SPACE;
         end else if (idx_ff < b2_ff) begin
            kind_in = K_SIGN;
         end else if (idx_ff < b3_ff) begin
            kind_in = (idx_ff == b2_ff) ? K_ZERO : K_X;
         end else if (idx_ff < b4_ff) begin
            kind_in = K_ZERO;
         end else if (idx_ff < b5_ff) begin
            kind_in = K_DIGIT;
         end else begin
            kind_in = K_SPACE;
         end
      end

      if (cmd.err) begin
         strobe_in = 1'b1;
         last_in   = 1'b1;
         kind_in   = K_ERR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      divc_ff      <= divc_in;
      nd_ff        <= nd_in;
      base_ff      <= base_in;
      width_ff     <= width_in;
      prec_ff      <= prec_in;
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      pc_ff        <= pc_in;
      lower_ff     <= lower_in;
      left_ff      <= left_in;
      zp_ff        <= zp_in;
      lead_ff      <= lead_in;
      zc_ff        <= zc_in;
      dig_ff       <= dig_in;
      trail_ff     <= trail_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      b3_ff        <= b3_in;
      b4_ff        <= b4_in;
      b5_ff        <= b5_in;
      n_ff         <= n_in;
      idx_ff       <= idx_in;
      last_ff      <= last_in;
      kind_ff      <= kind_in;
   end

   itf_ram #(
      .WIDTH (BW),
      .DEPTH (MAX_DIGITS)
   ) u_digit_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (nd_ff[AW-1:0]),
      .wr_data (r),
      .rd_en   (cmd.emit_step),
      .rd_addr (dig_addr[AW-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      status.bad_base    = (req_base < itf_pkg::BASE_MIN) || (req_base > itf_pkg::BASE_MAX);
      status.digit_end   = (divc_ff == DC_W'(DIV_CYCLES - 1));
      status.quot_zero   = (work_next == '0);
      status.digits_full = ((nd_ff + ND_W'(1)) == ND_W'(MAX_DIGITS));
      status.emit_none   = (n_ff == '0);
      status.emit_last   = (idx_ff == n_ff - CW'(1));
   end

   always_comb begin
      case (kind_ff)
         K_SPACE: rsp_out_char = itf_pkg::CHAR_SPACE;
         K_SIGN:  rsp_out_char = sign_char_ff;
         K_ZERO:  rsp_out_char = itf_pkg::CHAR_ZERO;
         K_X:     rsp_out_char = lower_ff ? itf_pkg::CHAR_X_LO : itf_pkg::CHAR_X_UP;
         K_DIGIT: rsp_out_char = itf_pkg::digit_char(rd_data, lower_ff);
         default: rsp_out_char = itf_pkg::CHAR_NUL;
      endcase
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_last_char = last_ff;
   assign rsp_bad_base  = (kind_ff == K_ERR);

endmodule

### rtl/integer_to_text_formatter.sv
// top level of the printf-style integer to text formatter
`timescale 1ns / 1ps

// integer to text formatter: a number is taken when start is high and busy low;
// its characters then leave one per cycle on rsp_out_char with rsp_strobe high,
// the final one flagged by rsp_last_char. the receiver cannot stall, so every
// beat must be taken in the cycle it is shown. a base outside 2 to 36 gives a
// single error beat in the next cycle and leaves busy low. otherwise an item
// is loaded, then divided digit by digit in the shared divide unit (8 quotient
// bits a cycle), then laid out in a length step and a position step, then
// emitted one character per cycle, the last beat showing in the same cycle
// that busy falls. a short field width can leave no character at all, in
// which case no beat is given

module integer_to_text_formatter #(
   parameter int VALUE_BITS = itf_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = itf_pkg::MAX_DIGITS_DEF,
   parameter int MAX_WIDTH  = itf_pkg::MAX_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [VALUE_BITS-1:0]               req_value,
   input  logic [itf_pkg::BASE_W-1:0]          req_base,
   input  logic signed [itf_pkg::WIDTH_W-1:0]  req_width,
   input  logic [itf_pkg::PREC_W-1:0]          req_precision,
   input  logic [itf_pkg::FLAG_W-1:0]          req_format_flags,
   output logic                                rsp_strobe,
   output logic [itf_pkg::CHAR_W-1:0]          rsp_out_char,
   output logic                                rsp_last_char,
   output logic                                rsp_bad_base
);

   // command and status between sequencer and datapath
   itf_pkg::ctrl_cmd_type  cmd;
   itf_pkg::dp_status_type status;

   // sequencer: load, divide, layout, emit
   itf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   // datapath: divide unit, digit store, layout counters, output beat register
   itf_datapath #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_DIGITS (MAX_DIGITS),
      .MAX_WIDTH  (MAX_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_base         (req_base),
      .req_width        (req_width),
      .req_precision    (req_precision),
      .req_format_flags (req_format_flags),
      .cmd              (cmd),
      .status           (status),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_char     (rsp_out_char),
      .rsp_last_char    (rsp_last_char),
      .rsp_bad_base     (rsp_bad_base)
   );

endmodule

### rtl/itf_checker.sv
// port-level checks of the formatter and their binding
`timescale 1ns / 1ps
`include "integer_to_text_formatter_defines.svh"

module itf_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                start,
   input logic                                busy,
   input logic [itf_pkg::BASE_W-1:0]          req_base,
   input logic                                rsp_strobe,
   input logic [itf_pkg::CHAR_W-1:0]          rsp_out_char,
   input logic                                rsp_last_char,
   input logic                                rsp_bad_base
);

   logic base_bad;
   logic taken;

   assign base_bad = (req_base < itf_pkg::BASE_MIN) || (req_base > itf_pkg::BASE_MAX);
   assign taken    = start && !busy;

   `ITF_ASSERT_NEXT(a_err_single, clock, reset, taken && base_bad, rsp_strobe && rsp_bad_base && rsp_last_char, "bad base did not give one error beat")
   `ITF_ASSERT_NEXT(a_busy_after_item, clock, reset, taken && !base_bad, busy, "good item did not raise busy")
   `ITF_ASSERT_NOW(a_text_nonzero, clock, reset, rsp_strobe && !rsp_bad_base, rsp_out_char != itf_pkg::CHAR_NUL, "text beat carries a nul")
   `ITF_ASSERT_NOW(a_idle_beat_is_err, clock, reset, rsp_strobe && !$past(busy), rsp_bad_base, "text beat while idle")

endmodule

bind integer_to_text_formatter itf_checker u_itf_checker (.*);
